// ----- rtl/esc_pkg.sv -----
// Shared types and constants for the epoch seconds to calendar converter.
`default_nettype none

package esc_pkg;

  // Reciprocal multipliers for exact division by small constants.
  // q = (x * recip) >> shift is exact over the whole operand range used.
  localparam logic [31:0] Recip60 = 32'h8888_8889;  // shift 37, any 32-bit x
  localparam logic [31:0] Recip3  = 32'hAAAA_AAAB;  // shift 33, any 32-bit x
  localparam logic [31:0] Recip7  = 32'h9249_2493;  // shift 34, x below 2^31

  localparam logic [31:0] SecsPerMin  = 32'd60;
  localparam logic [31:0] HoursPerDay = 32'd24;
  localparam logic [31:0] DaysPerWeek = 32'd7;
  localparam logic [31:0] EpochWday   = 32'd4;

  localparam logic [7:0] EpochYearOff = 8'd70;
  localparam logic [7:0] Year1900Off  = 8'd0;
  localparam logic [7:0] Year2100Off  = 8'd200;
  localparam logic [3:0] MonthLast    = 4'd11;

  // Divisor selection for the shared reciprocal multiplier.
  typedef enum logic [1:0] {
    DIV_60,
    DIV_24,
    DIV_7
  } div_e;

  // Where the remainder of a division step lands.
  typedef enum logic [1:0] {
    DST_SEC,
    DST_MIN,
    DST_HR,
    DST_WDAY
  } dst_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SEC,
    ST_QUO_SEC,
    ST_MUL_MIN,
    ST_QUO_MIN,
    ST_MUL_HR,
    ST_QUO_HR,
    ST_MUL_WD,
    ST_QUO_WD,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic quo;
    div_e sel;
    dst_e dst;
    logic year_sub;
    logic yday_cap;
    logic month_sub;
  } dp_cmd_t;

  typedef struct packed {
    logic year_ge;
    logic month_ge;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/esc_dp.sv -----
// Datapath: shared reciprocal multiplier, year and month subtraction registers.
`default_nettype none

module esc_dp (
  input  logic                 clk_i,
  input  logic [31:0]          epoch_seconds_i,
  input  esc_pkg::dp_cmd_t     cmd_i,
  output esc_pkg::dp_sts_t     sts_o,
  output logic [5:0]           second_of_minute_o,
  output logic [5:0]           minute_of_hour_o,
  output logic [4:0]           hour_of_day_o,
  output logic [4:0]           day_of_month_o,
  output logic [3:0]           month_index_o,
  output logic [7:0]           years_since_1900_o,
  output logic [8:0]           day_of_year_o,
  output logic [2:0]           weekday_o
);

  logic [31:0] acc_q, acc_d;
  logic [63:0] prod_q;
  logic [5:0]  sec_q, min_q;
  logic [4:0]  hr_q;
  logic [2:0]  wday_q;
  logic [7:0]  yr_q, yr_d;
  logic [3:0]  mon_q, mon_d;
  logic [8:0]  yday_q;

  logic [31:0] dividend, mul_op, recip, quo, divisor, quo_x_div;
  logic [5:0]  rem;
  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  month_len;

  // Years 1900 and 2100 are the only multiples of four in range that are not leap.
  assign leap = (yr_q[1:0] == 2'b00) && (yr_q != esc_pkg::Year1900Off)
                && (yr_q != esc_pkg::Year2100Off);
  assign year_len = leap ? 9'd366 : 9'd365;

  always_comb begin
    case (mon_q) inside
      4'd1:                   month_len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: month_len = 5'd30;
      default:                month_len = 5'd31;
    endcase
  end

  assign sts_o.year_ge  = acc_q >= 32'(year_len);
  assign sts_o.month_ge = (mon_q != esc_pkg::MonthLast) && (acc_q >= 32'(month_len));

  // The weekday step divides days + 4; the hour step divides by 24 as (x / 8) / 3.
  always_comb begin
    dividend = (cmd_i.sel == esc_pkg::DIV_7) ? acc_q + esc_pkg::EpochWday : acc_q;
    unique case (cmd_i.sel)
      esc_pkg::DIV_24: begin
        mul_op  = {3'b000, dividend[31:3]};
        recip   = esc_pkg::Recip3;
        quo     = {1'b0, prod_q[63:33]};
        divisor = esc_pkg::HoursPerDay;
      end
      esc_pkg::DIV_7: begin
        mul_op  = dividend;
        recip   = esc_pkg::Recip7;
        quo     = {2'b00, prod_q[63:34]};
        divisor = esc_pkg::DaysPerWeek;
      end
      default: begin
        mul_op  = dividend;
        recip   = esc_pkg::Recip60;
        quo     = {5'b00000, prod_q[63:37]};
        divisor = esc_pkg::SecsPerMin;
      end
    endcase
    quo_x_div = 32'(quo * divisor);
    rem       = 6'(dividend - quo_x_div);
  end

  always_comb begin
    acc_d = acc_q;
    yr_d  = yr_q;
    mon_d = mon_q;
    if (cmd_i.load) begin
      acc_d = epoch_seconds_i;
      yr_d  = esc_pkg::EpochYearOff;
      mon_d = 4'd0;
    end else if (cmd_i.quo && (cmd_i.dst != esc_pkg::DST_WDAY)) begin
      acc_d = quo;
    end else if (cmd_i.year_sub) begin
      acc_d = acc_q - 32'(year_len);
      yr_d  = yr_q + 8'd1;
    end else if (cmd_i.month_sub) begin
      acc_d = acc_q - 32'(month_len);
      mon_d = mon_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    yr_q  <= yr_d;
    mon_q <= mon_d;
    if (cmd_i.mul) begin
      prod_q <= 64'(mul_op) * 64'(recip);
    end
    if (cmd_i.yday_cap) begin
      yday_q <= acc_q[8:0];
    end
    if (cmd_i.quo) begin
      case (cmd_i.dst)
        esc_pkg::DST_SEC: sec_q  <= rem;
        esc_pkg::DST_MIN: min_q  <= rem;
        esc_pkg::DST_HR:  hr_q   <= rem[4:0];
        default:          wday_q <= rem[2:0];
      endcase
    end
  end

  assign second_of_minute_o = sec_q;
  assign minute_of_hour_o   = min_q;
  assign hour_of_day_o      = hr_q;
  assign day_of_month_o     = acc_q[4:0] + 5'd1;
  assign month_index_o      = mon_q;
  assign years_since_1900_o = yr_q;
  assign day_of_year_o      = yday_q;
  assign weekday_o          = wday_q;

endmodule

`default_nettype wire

// ----- rtl/esc_ctrl.sv -----
// Controller: sequences the division steps, the year walk and the month walk.
`default_nettype none

module esc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  esc_pkg::dp_sts_t sts_i,
  output esc_pkg::dp_cmd_t cmd_o,
  output logic             busy_o,
  output logic             valid_o
);

  esc_pkg::state_e state_q, state_d;
  logic accept;

  assign busy_o  = (state_q != esc_pkg::ST_IDLE) && (state_q != esc_pkg::ST_DONE);
  assign valid_o = (state_q == esc_pkg::ST_DONE);
  assign accept  = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      esc_pkg::ST_IDLE, esc_pkg::ST_DONE: begin
        state_d = accept ? esc_pkg::ST_MUL_SEC : esc_pkg::ST_IDLE;
      end
      esc_pkg::ST_MUL_SEC: state_d = esc_pkg::ST_QUO_SEC;
      esc_pkg::ST_QUO_SEC: state_d = esc_pkg::ST_MUL_MIN;
      esc_pkg::ST_MUL_MIN: state_d = esc_pkg::ST_QUO_MIN;
      esc_pkg::ST_QUO_MIN: state_d = esc_pkg::ST_MUL_HR;
      esc_pkg::ST_MUL_HR:  state_d = esc_pkg::ST_QUO_HR;
      esc_pkg::ST_QUO_HR:  state_d = esc_pkg::ST_MUL_WD;
      esc_pkg::ST_MUL_WD:  state_d = esc_pkg::ST_QUO_WD;
      esc_pkg::ST_QUO_WD:  state_d = esc_pkg::ST_YEAR;
      esc_pkg::ST_YEAR: begin
        if (!sts_i.year_ge) begin
          state_d = esc_pkg::ST_MONTH;
        end
      end
      esc_pkg::ST_MONTH: begin
        if (!sts_i.month_ge) begin
          state_d = esc_pkg::ST_DONE;
        end
      end
      default: state_d = esc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.sel = esc_pkg::DIV_60;
    cmd_o.dst = esc_pkg::DST_SEC;
    unique case (state_q)
      esc_pkg::ST_IDLE, esc_pkg::ST_DONE: cmd_o.load = accept;
      esc_pkg::ST_MUL_SEC: cmd_o.mul = 1'b1;
      esc_pkg::ST_QUO_SEC: cmd_o.quo = 1'b1;
      esc_pkg::ST_MUL_MIN: cmd_o.mul = 1'b1;
      esc_pkg::ST_QUO_MIN: begin
        cmd_o.quo = 1'b1;
        cmd_o.dst = esc_pkg::DST_MIN;
      end
      esc_pkg::ST_MUL_HR: begin
        cmd_o.mul = 1'b1;
        cmd_o.sel = esc_pkg::DIV_24;
      end
      esc_pkg::ST_QUO_HR: begin
        cmd_o.quo = 1'b1;
        cmd_o.sel = esc_pkg::DIV_24;
        cmd_o.dst = esc_pkg::DST_HR;
      end
      esc_pkg::ST_MUL_WD: begin
        cmd_o.mul = 1'b1;
        cmd_o.sel = esc_pkg::DIV_7;
      end
      esc_pkg::ST_QUO_WD: begin
        cmd_o.quo = 1'b1;
        cmd_o.sel = esc_pkg::DIV_7;
        cmd_o.dst = esc_pkg::DST_WDAY;
      end
      esc_pkg::ST_YEAR: begin
        cmd_o.year_sub = sts_i.year_ge;
        cmd_o.yday_cap = !sts_i.year_ge;
      end
      esc_pkg::ST_MONTH: cmd_o.month_sub = sts_i.month_ge;
      default: cmd_o.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= esc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/epoch_seconds_to_calendar_core.sv -----
// Top level of the epoch seconds to calendar converter.
`default_nettype none

// A word is accepted at a rising edge with start_i high and busy_o low. The
// block splits the 32-bit count of seconds since 1970-01-01 00:00:00 UTC into
// second, minute, hour, day of month, month (0 is January), years since 1900,
// day of year and weekday (0 is Sunday; 1970-01-01 was a Thursday). The result
// word appears for exactly one cycle, marked by valid_o, and the receiver must
// take it then: it cannot stall the block. A word passes through the division
// steps, then a year walk and a month walk through the final year, before
// valid_o rises. The year walk dominates: one year is subtracted per cycle. The
// divisions by 60, 60, 24 and 7 share one 32 by 32 reciprocal multiplier, each
// as a multiply state and a quotient state. A new word may be started in the
// same cycle that valid_o is shown. The block keeps no state between words.
module epoch_seconds_to_calendar_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] epoch_seconds_i,
  output logic        busy_o,
  output logic        valid_o,
  output logic [5:0]  second_of_minute_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [4:0]  hour_of_day_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_index_o,
  output logic [7:0]  years_since_1900_o,
  output logic [8:0]  day_of_year_o,
  output logic [2:0]  weekday_o
);

  esc_pkg::dp_cmd_t cmd;
  esc_pkg::dp_sts_t sts;

  // The controller owns the handshake and issues one datapath command a cycle.
  esc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .valid_o (valid_o)
  );

  // The datapath holds the running day count and all result fields.
  esc_dp u_dp (
    .clk_i              (clk_i),
    .epoch_seconds_i    (epoch_seconds_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .second_of_minute_o (second_of_minute_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .hour_of_day_o      (hour_of_day_o),
    .day_of_month_o     (day_of_month_o),
    .month_index_o      (month_index_o),
    .years_since_1900_o (years_since_1900_o),
    .day_of_year_o      (day_of_year_o),
    .weekday_o          (weekday_o)
  );

  // The result strobe lasts a single cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |=> !valid_o)
    else $error("result strobe held longer than one cycle");

  // An accepted word keeps the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (start_i && !busy_o) |=> (busy_o && !valid_o))
    else $error("accepted word did not start a conversion");

  // Every time field of a delivered word is within its range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid_o |-> (second_of_minute_o < 6'd60) && (minute_of_hour_o < 6'd60)
                               && (hour_of_day_o < 5'd24) && (weekday_o < 3'd7))
    else $error("time of day or weekday out of range");

  // The month walk ends inside the year and inside the month.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid_o |-> (month_index_o <= 4'd11) && (day_of_month_o != 5'd0)
                               && (day_of_year_o <= 9'd365))
    else $error("calendar date out of range");

endmodule

`default_nettype wire
